[hw/rtl/aps_pkg.sv]
package aps_pkg;

    localparam int TICKS_W   = 8;
    localparam int FAIL_W    = 5;
    localparam int MODE_W    = 3;
    localparam int GOAL_W    = 13;
    localparam int MPT_W     = 4;
    localparam int ELAPSED_W = 14;
    localparam int PROD_W    = TICKS_W + MPT_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [ELAPSED_W-1:0] TIMER_MAX = 14'd16383;

    localparam logic [MODE_W-1:0] MODE_STANDBY    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WARM_LOW   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ON_LOW     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WARM_HIGH  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ON_HIGH    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POWER_DOWN = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FAILURE    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_LOW_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STANDBY_HOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MS_PER_TICK  = 2'd3;

    localparam logic [GOAL_W-1:0] WARMUP_LOW_RST   = 13'd2000;
    localparam logic [GOAL_W-1:0] ON_LOW_HOLD_RST  = 13'd5000;
    localparam logic [GOAL_W-1:0] STANDBY_HOLD_RST = 13'd500;
    localparam logic [MPT_W-1:0]  MS_PER_TICK_RST  = 4'd8;

    // Power relay bits: small supply, small live, big supply, big live.
    localparam logic [3:0] PWR_OFF       = 4'h0;
    localparam logic [3:0] PWR_WARM_LOW  = 4'h1;
    localparam logic [3:0] PWR_ON_LOW    = 4'h3;
    localparam logic [3:0] PWR_WARM_HIGH = 4'h7;
    localparam logic [3:0] PWR_ON_HIGH   = 4'hF;
    localparam logic [3:0] PWR_DOWN      = 4'h5;

    typedef struct packed {
        logic [GOAL_W-1:0] warmup_low_ms;
        logic [GOAL_W-1:0] on_low_hold_ms;
        logic [GOAL_W-1:0] standby_hold_ms;
        logic [MPT_W-1:0]  ms_per_tick;
    } cfg_t;

    typedef struct packed {
        logic [TICKS_W-1:0] elapsed_ticks;
        logic               power_key;
        logic               bridge_switch;
        logic               high_power_request;
        logic               high_supply_stable;
        logic [FAIL_W-1:0]  new_failures;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FAIL_W-1:0] failure_latch;
        logic              led_red;
        logic              led_green;
        logic              led_blue;
        logic              small_supply_relay;
        logic              small_live_relay;
        logic              big_supply_relay;
        logic              big_live_relay;
        logic              front_output_relay;
        logic              rear_output_relay;
        logic              bridge_relay;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [FAIL_W-1:0]    failures;
        logic [ELAPSED_W-1:0] timer_elapsed;
        logic [GOAL_W-1:0]    timer_goal;
        logic                 front_relay;
        logic                 rear_relay;
        logic                 bridge_relay;
        logic [3:0]           power_relays;
    } state_t;

    localparam state_t STATE_RST = '{
        mode:          MODE_STANDBY,
        failures:      '0,
        timer_elapsed: '0,
        timer_goal:    '0,
        front_relay:   1'b0,
        rear_relay:    1'b0,
        bridge_relay:  1'b0,
        power_relays:  PWR_OFF
    };

endpackage

[hw/rtl/aps_item_if.sv]
interface aps_item_if;

    logic                           valid;
    logic                           ready;
    logic [aps_pkg::TICKS_W-1:0]    elapsed_ticks;
    logic                           power_key;
    logic                           bridge_switch;
    logic                           high_power_request;
    logic                           high_supply_stable;
    logic [aps_pkg::FAIL_W-1:0]     new_failures;

    modport source (
        output valid, elapsed_ticks, power_key, bridge_switch,
               high_power_request, high_supply_stable, new_failures,
        input  ready
    );

    modport sink (
        input  valid, elapsed_ticks, power_key, bridge_switch,
               high_power_request, high_supply_stable, new_failures,
        output ready
    );

endinterface

[hw/rtl/aps_result_if.sv]
interface aps_result_if;

    logic                        valid;
    logic                        ready;
    logic [aps_pkg::MODE_W-1:0]  mode;
    logic [aps_pkg::FAIL_W-1:0]  failure_latch;
    logic                        led_red;
    logic                        led_green;
    logic                        led_blue;
    logic                        small_supply_relay;
    logic                        small_live_relay;
    logic                        big_supply_relay;
    logic                        big_live_relay;
    logic                        front_output_relay;
    logic                        rear_output_relay;
    logic                        bridge_relay;

    modport source (
        output valid, mode, failure_latch, led_red, led_green, led_blue,
               small_supply_relay, small_live_relay, big_supply_relay,
               big_live_relay, front_output_relay, rear_output_relay,
               bridge_relay,
        input  ready
    );

    modport sink (
        input  valid, mode, failure_latch, led_red, led_green, led_blue,
               small_supply_relay, small_live_relay, big_supply_relay,
               big_live_relay, front_output_relay, rear_output_relay,
               bridge_relay,
        output ready
    );

endinterface

[hw/rtl/aps_cfg_if.sv]
interface aps_cfg_if;

    logic                             valid;
    logic                             ready;
    logic [aps_pkg::CFG_IDX_W-1:0]    index;
    logic [aps_pkg::CFG_DAT_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

[hw/rtl/aps_cfg_regs.sv]
module aps_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    aps_cfg_if.sink       cfg,
    output aps_pkg::cfg_t regs
);

    aps_pkg::cfg_t regs_reg;
    aps_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                aps_pkg::REG_WARMUP_LOW:   regs_next.warmup_low_ms   = cfg.data;
                aps_pkg::REG_ON_LOW_HOLD:  regs_next.on_low_hold_ms  = cfg.data;
                aps_pkg::REG_STANDBY_HOLD: regs_next.standby_hold_ms = cfg.data;
                aps_pkg::REG_MS_PER_TICK:
                    regs_next.ms_per_tick = cfg.data[aps_pkg::MPT_W-1:0];
                default: regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.warmup_low_ms   <= aps_pkg::WARMUP_LOW_RST;
            regs_reg.on_low_hold_ms  <= aps_pkg::ON_LOW_HOLD_RST;
            regs_reg.standby_hold_ms <= aps_pkg::STANDBY_HOLD_RST;
            regs_reg.ms_per_tick     <= aps_pkg::MS_PER_TICK_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

[hw/rtl/aps_step.sv]
module aps_step (
    input  aps_pkg::item_t   item_word,
    input  aps_pkg::state_t  state_cur,
    input  aps_pkg::cfg_t    cfg_word,
    output aps_pkg::state_t  state_next,
    output aps_pkg::result_t res_word
);

    logic [aps_pkg::PROD_W-1:0]      prod;
    logic [aps_pkg::ELAPSED_W:0]     sum;
    logic [aps_pkg::ELAPSED_W-1:0]   elapsed_adv;
    logic                            timer_done;
    logic [aps_pkg::FAIL_W-1:0]      fail_all;
    logic [aps_pkg::MODE_W-1:0]      mode_in;
    logic [aps_pkg::MODE_W-1:0]      mode_new;
    logic [aps_pkg::ELAPSED_W-1:0]   elapsed_new;
    logic [aps_pkg::GOAL_W-1:0]      goal_new;
    aps_pkg::state_t                 st;
    logic                            red;
    logic                            green;
    logic                            blue;

    assign prod = aps_pkg::PROD_W'(item_word.elapsed_ticks)
                * aps_pkg::PROD_W'(cfg_word.ms_per_tick);
    assign sum  = {1'b0, state_cur.timer_elapsed}
                + (aps_pkg::ELAPSED_W + 1)'(prod);

    always_comb
    begin
        if (state_cur.timer_elapsed < {1'b0, state_cur.timer_goal})
        begin
            if (sum > {1'b0, aps_pkg::TIMER_MAX})
                elapsed_adv = aps_pkg::TIMER_MAX;
            else
                elapsed_adv = sum[aps_pkg::ELAPSED_W-1:0];
        end
        else
        begin
            elapsed_adv = state_cur.timer_elapsed;
        end
    end

    assign timer_done = elapsed_adv >= {1'b0, state_cur.timer_goal};
    assign fail_all   = state_cur.failures | item_word.new_failures;
    assign mode_in    = (fail_all != '0) ? aps_pkg::MODE_FAILURE : state_cur.mode;

    // Later rules win: a finished timer, a high-power request or a stable high supply overrides a cancel.
    always_comb
    begin
        mode_new    = mode_in;
        elapsed_new = elapsed_adv;
        goal_new    = state_cur.timer_goal;
        case (mode_in)
            aps_pkg::MODE_STANDBY:
            begin
                if (item_word.power_key)
                begin
                    mode_new    = aps_pkg::MODE_WARM_LOW;
                    elapsed_new = '0;
                    goal_new    = cfg_word.warmup_low_ms;
                end
            end
            aps_pkg::MODE_WARM_LOW:
            begin
                if (!item_word.power_key)
                    mode_new = aps_pkg::MODE_POWER_DOWN;
                if (timer_done)
                begin
                    mode_new    = aps_pkg::MODE_ON_LOW;
                    elapsed_new = '0;
                    goal_new    = cfg_word.on_low_hold_ms;
                end
            end
            aps_pkg::MODE_ON_LOW:
            begin
                if (!item_word.power_key)
                    mode_new = aps_pkg::MODE_POWER_DOWN;
                if (item_word.high_power_request)
                    mode_new = aps_pkg::MODE_WARM_HIGH;
            end
            aps_pkg::MODE_WARM_HIGH:
            begin
                if (!item_word.power_key)
                    mode_new = aps_pkg::MODE_POWER_DOWN;
                if (item_word.high_supply_stable)
                    mode_new = aps_pkg::MODE_ON_HIGH;
            end
            aps_pkg::MODE_ON_HIGH:
            begin
                if (!item_word.power_key)
                    mode_new = aps_pkg::MODE_POWER_DOWN;
            end
            aps_pkg::MODE_POWER_DOWN:
            begin
                if (timer_done)
                begin
                    mode_new    = aps_pkg::MODE_STANDBY;
                    elapsed_new = '0;
                    goal_new    = cfg_word.standby_hold_ms;
                end
            end
            default: mode_new = mode_in;
        endcase
    end

    // Relays without a rule for the new mode keep their previous level.
    always_comb
    begin
        st               = state_cur;
        st.mode          = mode_new;
        st.failures      = fail_all;
        st.timer_elapsed = elapsed_new;
        st.timer_goal    = goal_new;
        red   = 1'b0;
        green = 1'b0;
        blue  = 1'b0;
        case (mode_new)
            aps_pkg::MODE_STANDBY:
            begin
                st.power_relays = aps_pkg::PWR_OFF;
                st.front_relay  = 1'b0;
                st.rear_relay   = 1'b0;
                st.bridge_relay = 1'b0;
            end
            aps_pkg::MODE_FAILURE:
            begin
                st.power_relays = aps_pkg::PWR_OFF;
                st.front_relay  = 1'b0;
                st.rear_relay   = 1'b0;
                red = 1'b1;
            end
            aps_pkg::MODE_WARM_LOW:
            begin
                st.power_relays = aps_pkg::PWR_WARM_LOW;
                st.front_relay  = 1'b0;
                st.rear_relay   = 1'b0;
                st.bridge_relay = item_word.bridge_switch;
                red   = 1'b1;
                green = 1'b1;
            end
            aps_pkg::MODE_ON_LOW:
            begin
                st.power_relays = aps_pkg::PWR_ON_LOW;
                st.front_relay  = 1'b1;
                st.rear_relay   = !item_word.bridge_switch;
                green = 1'b1;
            end
            aps_pkg::MODE_WARM_HIGH:
            begin
                st.power_relays = aps_pkg::PWR_WARM_HIGH;
                st.front_relay  = 1'b1;
                st.rear_relay   = !item_word.bridge_switch;
                red   = 1'b1;
                green = 1'b1;
            end
            aps_pkg::MODE_ON_HIGH:
            begin
                st.power_relays = aps_pkg::PWR_ON_HIGH;
                st.front_relay  = 1'b1;
                st.rear_relay   = !item_word.bridge_switch;
                blue = 1'b1;
            end
            aps_pkg::MODE_POWER_DOWN:
            begin
                st.power_relays = aps_pkg::PWR_DOWN;
                red   = 1'b1;
                green = 1'b1;
                blue  = 1'b1;
            end
            default: st.power_relays = state_cur.power_relays;
        endcase
    end

    assign state_next = st;

    assign res_word.mode               = st.mode;
    assign res_word.failure_latch      = st.failures;
    assign res_word.led_red            = red;
    assign res_word.led_green          = green;
    assign res_word.led_blue           = blue;
    assign res_word.small_supply_relay = st.power_relays[0];
    assign res_word.small_live_relay   = st.power_relays[1];
    assign res_word.big_supply_relay   = st.power_relays[2];
    assign res_word.big_live_relay     = st.power_relays[3];
    assign res_word.front_output_relay = st.front_relay;
    assign res_word.rear_output_relay  = st.rear_relay;
    assign res_word.bridge_relay       = st.bridge_relay;

endmodule

[hw/rtl/amp_power_sequencer.sv]
// Channel   Modport   Word
// item      sink      one loop tick: ticks, button, switches, new failure bits
// result    source    mode, failure latch, lamp levels and relay levels
// cfg       sink      register index and write data, always ready
//
// Each word passes an input register and a result register, and one word
// is accepted in every cycle while the result channel does not stall. The
// step logic updates the sequencer state in the same cycle that loads the
// result register. Reset sets the configuration registers to their defaults,
// the mode to standby and all relays off. A stalled result holds the input
// register, and the item channel then takes no further word until the
// result register drains.
module amp_power_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    aps_item_if.sink      item,
    aps_result_if.source  result,
    aps_cfg_if.sink       cfg
);

    aps_pkg::cfg_t    cfg_regs;
    aps_pkg::item_t   item_reg;
    logic             item_valid_reg;
    aps_pkg::state_t  state_reg;
    aps_pkg::state_t  state_next;
    aps_pkg::result_t res_reg;
    aps_pkg::result_t res_next;
    logic             res_valid_reg;
    logic             fire;
    logic             take;

    aps_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    aps_step u_step (
        .item_word  (item_reg),
        .state_cur  (state_reg),
        .cfg_word   (cfg_regs),
        .state_next (state_next),
        .res_word   (res_next)
    );

    assign fire       = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || fire;
    assign take       = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= aps_pkg::STATE_RST;
        end
        else
        begin
            if (item.ready)
                item_valid_reg <= item.valid;
            if (fire)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.elapsed_ticks      <= item.elapsed_ticks;
            item_reg.power_key          <= item.power_key;
            item_reg.bridge_switch      <= item.bridge_switch;
            item_reg.high_power_request <= item.high_power_request;
            item_reg.high_supply_stable <= item.high_supply_stable;
            item_reg.new_failures       <= item.new_failures;
        end
        if (fire)
            res_reg <= res_next;
    end

    assign result.valid              = res_valid_reg;
    assign result.mode               = res_reg.mode;
    assign result.failure_latch      = res_reg.failure_latch;
    assign result.led_red            = res_reg.led_red;
    assign result.led_green          = res_reg.led_green;
    assign result.led_blue           = res_reg.led_blue;
    assign result.small_supply_relay = res_reg.small_supply_relay;
    assign result.small_live_relay   = res_reg.small_live_relay;
    assign result.big_supply_relay   = res_reg.big_supply_relay;
    assign result.big_live_relay     = res_reg.big_live_relay;
    assign result.front_output_relay = res_reg.front_output_relay;
    assign result.rear_output_relay  = res_reg.rear_output_relay;
    assign result.bridge_relay       = res_reg.bridge_relay;

    a_fail_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.failure_latch != '0))
            |-> (result.mode == aps_pkg::MODE_FAILURE))
        else $error("failure latched but mode is not failure");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == aps_pkg::MODE_FAILURE)
            |=> (state_reg.mode == aps_pkg::MODE_FAILURE))
        else $error("sequencer left the failure state");

    a_big_live_on_high: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.big_live_relay)
            |-> (result.mode == aps_pkg::MODE_ON_HIGH))
        else $error("big live relay closed outside on-high");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !fire) |-> !item.ready)
        else $error("input register taken while its word is still pending");

endmodule
